>>> hdl/i2cms_pkg.sv
// Shared types and constants for the I2C master event sequencer.
// No dependencies; imported by i2cms_step and i2c_master_event_sequencer.
package i2cms_pkg;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_SEND  = 2'd1,
    ST_RECV  = 2'd2
  } xfer_state_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_EVENT = 1'b1
  } op_e;

  // Bit positions in status_flags.
  localparam int unsigned FlgStartSent = 0;
  localparam int unsigned FlgAddrSent  = 1;
  localparam int unsigned FlgByteDone  = 2;
  localparam int unsigned FlgStop      = 3;
  localparam int unsigned FlgTxEmpty   = 4;
  localparam int unsigned FlgRxFull    = 5;

  // Bit positions in the events mask.
  localparam int unsigned EvTxDone   = 0;
  localparam int unsigned EvStop     = 1;
  localparam int unsigned EvRxDone   = 2;
  localparam int unsigned EvDataReq  = 3;
  localparam int unsigned EvDataSent = 4;

  typedef struct packed {
    logic       op;
    logic       direction;
    logic [6:0] slave_address;
    logic [15:0] transfer_length;
    logic       repeat_start;
    logic [5:0] status_flags;
    logic       master_mode;
    logic       transmitter;
    logic [7:0] rx_data;
    logic [7:0] tx_data;
  } item_t;

  // Transfer control state apart from the byte counters.
  typedef struct packed {
    xfer_state_e xfer_state;
    logic [6:0]  target_addr;
    logic        hold_bus;
    logic        ack_bit;
    logic        irq_on;
  } xfer_ctl_t;

  typedef struct packed {
    logic [1:0] prior_state;
    logic       dr_write;
    logic [7:0] dr_value;
    logic       tx_byte_used;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       gen_start;
    logic       gen_stop;
    logic       addr_clear;
    logic       ack_enable;
    logic       irq_enable;
    logic [4:0] events;
  } result_t;

endpackage

>>> hdl/i2c_master_event_sequencer.sv
// Top level of the I2C master event sequencer: input register, transfer
// state, result register. Depends on i2cms_pkg and i2cms_step.
//
// Usage: the driver offers start and event beats on the in_* channel
// (valid/ready). A start beat (op 0) latches direction, address, length and
// repeat-start when the sequencer is ready and is dropped otherwise. An event
// beat (op 1) carries the peripheral status flags and data bytes. Every
// accepted beat yields exactly one result beat on the out_* channel with the
// driver actions and a notice mask.
// An accepted beat moves from the input register through the combinational
// transfer-state update into the result register, which drives the outputs.
// Throughput is one beat per cycle while the receiver takes results. When the
// receiver stalls, the result register holds and the input register keeps one
// more beat; in_ready_o drops once both are full. Write ack_default through
// cfg_we_i/cfg_wdata_i only while no beat is in flight; the sequencer does not
// enforce this. Reset brings the sequencer to ready with both counters at zero,
// interrupts off, acknowledge on and ack_default at one.
module i2c_master_event_sequencer #(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic        direction_i,
  input  logic [6:0]  slave_address_i,
  input  logic [15:0] transfer_length_i,
  input  logic        repeat_start_i,
  input  logic [5:0]  status_flags_i,
  input  logic        master_mode_i,
  input  logic        transmitter_i,
  input  logic [7:0]  rx_data_i,
  input  logic [7:0]  tx_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  prior_state_o,
  output logic        dr_write_o,
  output logic [7:0]  dr_value_o,
  output logic        tx_byte_used_o,
  output logic        rx_valid_o,
  output logic [7:0]  rx_byte_o,
  output logic        gen_start_o,
  output logic        gen_stop_o,
  output logic        addr_clear_o,
  output logic        ack_enable_o,
  output logic        irq_enable_o,
  output logic [4:0]  events_o
);
  import i2cms_pkg::*;

  logic                 ack_default_q;
  logic                 s1_valid_q;
  item_t                s1_item_q;
  logic                 out_valid_q;
  result_t              res_q;
  xfer_ctl_t            ctl_q, ctl_d;
  logic [LEN_WIDTH-1:0] tx_left_q, tx_left_d;
  logic [LEN_WIDTH-1:0] rx_left_q, rx_left_d;
  result_t              res_d;
  logic                 advance;
  logic                 in_fire;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  i2cms_step #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_step (
    .item_i       (s1_item_q),
    .ctl_i        (ctl_q),
    .tx_left_i    (tx_left_q),
    .rx_left_i    (rx_left_q),
    .ack_default_i(ack_default_q),
    .ctl_o        (ctl_d),
    .tx_left_o    (tx_left_d),
    .rx_left_o    (rx_left_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_default_q <= 1'b1;
    end else if (cfg_we_i) begin
      ack_default_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_q       <= '{xfer_state: ST_READY, target_addr: '0, hold_bus: 1'b0,
                       ack_bit: 1'b1, irq_on: 1'b0};
      tx_left_q   <= '0;
      rx_left_q   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        ctl_q       <= ctl_d;
        tx_left_q   <= tx_left_d;
        rx_left_q   <= rx_left_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{op: op_i, direction: direction_i, slave_address: slave_address_i,
                     transfer_length: transfer_length_i, repeat_start: repeat_start_i,
                     status_flags: status_flags_i, master_mode: master_mode_i,
                     transmitter: transmitter_i, rx_data: rx_data_i, tx_data: tx_data_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign prior_state_o  = res_q.prior_state;
  assign dr_write_o     = res_q.dr_write;
  assign dr_value_o     = res_q.dr_value;
  assign tx_byte_used_o = res_q.tx_byte_used;
  assign rx_valid_o     = res_q.rx_valid;
  assign rx_byte_o      = res_q.rx_byte;
  assign gen_start_o    = res_q.gen_start;
  assign gen_stop_o     = res_q.gen_stop;
  assign addr_clear_o   = res_q.addr_clear;
  assign ack_enable_o   = res_q.ack_enable;
  assign irq_enable_o   = res_q.irq_enable;
  assign events_o       = res_q.events;

  // A start condition is only requested out of the ready state.
  a_start_from_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gen_start_o |-> prior_state_o == ST_READY)
    else $error("start requested while busy");

  // Received bytes are only delivered during a receive.
  a_rx_in_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_valid_o |-> prior_state_o == ST_RECV)
    else $error("received byte outside a receive");

  // A consumed transmit byte always goes to the data register.
  a_used_writes_dr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_byte_used_o |-> dr_write_o)
    else $error("transmit byte consumed without a data register write");

  // The transfer state only moves when a beat passes into the result register.
  a_state_moves_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(ctl_q) && $stable(tx_left_q) && $stable(rx_left_q))
    else $error("transfer state changed without a beat");

endmodule

>>> hdl/i2cms_step.sv
// Combinational handling of one beat: next transfer state and the result.
// Depends on i2cms_pkg.
module i2cms_step #(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  i2cms_pkg::item_t     item_i,
  input  i2cms_pkg::xfer_ctl_t ctl_i,
  input  logic [LEN_WIDTH-1:0] tx_left_i,
  input  logic [LEN_WIDTH-1:0] rx_left_i,
  input  logic                 ack_default_i,
  output i2cms_pkg::xfer_ctl_t ctl_o,
  output logic [LEN_WIDTH-1:0] tx_left_o,
  output logic [LEN_WIDTH-1:0] rx_left_o,
  output i2cms_pkg::result_t   res_o
);
  import i2cms_pkg::*;

  localparam logic [LEN_WIDTH-1:0] One = LEN_WIDTH'(1);

  logic [31:0]          len_ext;
  logic [LEN_WIDTH-1:0] len;

  assign len_ext = {16'b0, item_i.transfer_length};
  assign len     = len_ext[LEN_WIDTH-1:0];

  always_comb begin
    xfer_ctl_t            c;
    logic [LEN_WIDTH-1:0] tx;
    logic [LEN_WIDTH-1:0] rx;
    result_t              r;

    c  = ctl_i;
    tx = tx_left_i;
    rx = rx_left_i;
    r  = '0;
    r.prior_state = ctl_i.xfer_state;

    if (item_i.op == OP_START) begin
      // A start while busy is dropped.
      if (c.xfer_state == ST_READY) begin
        c.target_addr = item_i.slave_address;
        c.hold_bus    = item_i.repeat_start;
        if (item_i.direction) begin
          rx           = len;
          c.xfer_state = ST_RECV;
        end else begin
          tx           = len;
          c.xfer_state = ST_SEND;
        end
        r.gen_start = 1'b1;
        c.irq_on    = 1'b1;
      end
    end else begin
      if (item_i.status_flags[FlgStartSent]) begin
        if (c.xfer_state == ST_SEND) begin
          r.dr_write = 1'b1;
          r.dr_value = {c.target_addr, 1'b0};
        end else if (c.xfer_state == ST_RECV) begin
          r.dr_write = 1'b1;
          r.dr_value = {c.target_addr, 1'b1};
        end
      end
      if (item_i.status_flags[FlgAddrSent]) begin
        // A single-byte read must NACK its only byte.
        if (c.xfer_state == ST_RECV && rx == One) c.ack_bit = 1'b0;
        r.addr_clear = 1'b1;
      end
      if (item_i.status_flags[FlgByteDone]) begin
        if (c.xfer_state == ST_SEND && tx == '0) begin
          if (!c.hold_bus) r.gen_stop = 1'b1;
          c.irq_on     = 1'b0;
          c.xfer_state = ST_READY;
          tx           = '0;
          r.events[EvTxDone] = 1'b1;
        end
      end
      if (item_i.status_flags[FlgStop]) r.events[EvStop] = 1'b1;
      if (item_i.status_flags[FlgTxEmpty]) begin
        if (item_i.master_mode) begin
          if (c.xfer_state == ST_SEND && tx != '0) begin
            r.dr_write     = 1'b1;
            r.dr_value     = item_i.tx_data;
            r.tx_byte_used = 1'b1;
            tx             = tx - One;
            if (tx == '0) begin
              if (!c.hold_bus) r.gen_stop = 1'b1;
              c.irq_on     = 1'b0;
              c.xfer_state = ST_READY;
            end
          end
          if (tx == '0) r.events[EvTxDone] = 1'b1;
        end else if (item_i.transmitter) begin
          r.events[EvDataReq] = 1'b1;
        end
      end
      if (item_i.status_flags[FlgRxFull]) begin
        if (item_i.master_mode) begin
          if (c.xfer_state == ST_RECV) begin
            if (rx == One) begin
              r.gen_stop = 1'b1;
              r.rx_valid = 1'b1;
              r.rx_byte  = item_i.rx_data;
              rx         = '0;
            end else if (rx != '0) begin
              r.rx_valid = 1'b1;
              r.rx_byte  = item_i.rx_data;
              rx         = rx - One;
              if (rx == One) c.ack_bit = 1'b0;
            end
          end
          // An empty receive counter closes the receive whatever the state.
          if (rx == '0) begin
            c.irq_on     = 1'b0;
            c.xfer_state = ST_READY;
            c.ack_bit    = ack_default_i;
            r.events[EvRxDone] = 1'b1;
          end
        end else if (item_i.transmitter) begin
          r.events[EvDataSent] = 1'b1;
        end
      end
    end

    r.ack_enable = c.ack_bit;
    r.irq_enable = c.irq_on;

    ctl_o     = c;
    tx_left_o = tx;
    rx_left_o = rx;
    res_o     = r;
  end

endmodule
